FILE: src/pha_pkg.sv
// shared types, constants and helpers of the pipeline hazard and advance block
package pha_pkg;

  localparam int unsigned NUM_STAGES     = 7;
  localparam int unsigned ADDR_WIDTH_DEF = 32;
  localparam logic [7:0]  REG_NONE       = 8'd255;
  localparam logic [1:0]  SQUASH_TICKS   = 2'd3;

  typedef enum logic [3:0] {
    KIND_NOP      = 4'd0,
    KIND_RTYPE    = 4'd1,
    KIND_ITYPE    = 4'd2,
    KIND_LOAD     = 4'd3,
    KIND_STORE    = 4'd4,
    KIND_BRANCH   = 4'd5,
    KIND_JUMP     = 4'd6,
    KIND_SPECIAL  = 4'd7,
    KIND_JREG     = 4'd8,
    KIND_SQUASHED = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    HZ_NONE      = 3'd0,
    HZ_LOAD_NEAR = 3'd1,
    HZ_LOAD_FAR  = 3'd2,
    HZ_SQUASH    = 3'd3,
    HZ_STRUCT    = 3'd4
  } hazard_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_BUBBLE,
    OP_SQUASH
  } cell_op_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] src_a;
    logic [7:0] src_b;
    logic [7:0] dest;
  } slot_meta_t;

  // load in ld feeds a source of the consumer cons
  function automatic logic load_use(slot_meta_t ld, slot_meta_t cons);
    logic hit;
    hit = 1'b0;
    if (ld.kind == KIND_LOAD) begin
      if (cons.kind inside {KIND_RTYPE, KIND_STORE, KIND_BRANCH}) begin
        hit = (ld.dest != REG_NONE) &&
              ((ld.dest == cons.src_a) || (ld.dest == cons.src_b));
      end else if (cons.kind == KIND_ITYPE) begin
        hit = (ld.dest == cons.src_a);
      end
    end
    return hit;
  endfunction

endpackage

FILE: src/pha_if.sv
// valid/ready channel interfaces for instruction and retire items
interface pha_in_if;
  logic        valid;
  logic        ready;
  logic        instr_valid;
  logic [3:0]  instr_kind;
  logic [7:0]  instr_src_a;
  logic [7:0]  instr_src_b;
  logic [7:0]  instr_dest;
  logic [31:0] instr_pc;
  logic [31:0] instr_target;

  modport source (
    output valid, instr_valid, instr_kind, instr_src_a, instr_src_b,
           instr_dest, instr_pc, instr_target,
    input  ready
  );
  modport sink (
    input  valid, instr_valid, instr_kind, instr_src_a, instr_src_b,
           instr_dest, instr_pc, instr_target,
    output ready
  );
endinterface

interface pha_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  retire_kind;
  logic [7:0]  retire_src_a;
  logic [7:0]  retire_src_b;
  logic [7:0]  retire_dest;
  logic [31:0] retire_pc;
  logic [31:0] retire_target;
  logic [2:0]  hazard_code;

  modport source (
    output valid, accepted, retire_kind, retire_src_a, retire_src_b,
           retire_dest, retire_pc, retire_target, hazard_code,
    input  ready
  );
  modport sink (
    input  valid, accepted, retire_kind, retire_src_a, retire_src_b,
           retire_dest, retire_pc, retire_target, hazard_code,
    output ready
  );
endinterface

FILE: src/pha_cell.sv
// one pipeline stage slot: hold, take the neighbor's slot, or turn into a bubble or a squashed slot
module pha_cell import pha_pkg::*; #(
  parameter int unsigned AddrWidth = ADDR_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_op_e             op_i,
  input  slot_meta_t           prev_meta_i,
  input  logic [AddrWidth-1:0] prev_pc_i,
  input  logic [AddrWidth-1:0] prev_target_i,
  output slot_meta_t           meta_o,
  output logic [AddrWidth-1:0] pc_o,
  output logic [AddrWidth-1:0] target_o
);

  slot_meta_t           meta_q, meta_d;
  logic [AddrWidth-1:0] pc_q, pc_d;
  logic [AddrWidth-1:0] target_q, target_d;

  always_comb begin
    meta_d   = meta_q;
    pc_d     = pc_q;
    target_d = target_q;
    case (op_i)
      OP_HOLD: begin
      end
      OP_SHIFT: begin
        meta_d   = prev_meta_i;
        pc_d     = prev_pc_i;
        target_d = prev_target_i;
      end
      OP_BUBBLE: begin
        meta_d      = '0;
        meta_d.kind = KIND_NOP;
        pc_d        = '0;
        target_d    = '0;
      end
      OP_SQUASH: begin
        meta_d      = '0;
        meta_d.kind = KIND_SQUASHED;
        pc_d        = '0;
        target_d    = '0;
      end
      default: begin
      end
    endcase
  end

  // slot contents reach the retire port, so reset clears them too
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q   <= '{kind: KIND_NOP, default: '0};
      pc_q     <= '0;
      target_q <= '0;
    end else begin
      meta_q   <= meta_d;
      pc_q     <= pc_d;
      target_q <= target_d;
    end
  end

  assign meta_o   = meta_q;
  assign pc_o     = pc_q;
  assign target_o = target_q;

endmodule

FILE: src/pha_ctrl.sv
// hazard checks, squash counter and per-stage shift control
module pha_ctrl import pha_pkg::*; #(
  parameter int unsigned AddrWidth = ADDR_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tick_i,
  input  slot_meta_t [NUM_STAGES-1:0]       meta_i,
  input  logic [AddrWidth-1:0]              pc1_i,
  input  logic [AddrWidth-1:0]              target2_i,
  output cell_op_e   [NUM_STAGES-1:0]       ops_o,
  output hazard_e                           code_o,
  output logic                              advance_o
);

  logic [1:0] squash_left_q, squash_left_d;
  logic [1:0] squash_eff;
  hazard_e    code;

  always_comb begin
    code = HZ_NONE;
    if (load_use(meta_i[3], meta_i[2])) begin
      code = HZ_LOAD_NEAR;
    end else if (load_use(meta_i[4], meta_i[2])) begin
      code = HZ_LOAD_FAR;
    end else if (meta_i[2].kind inside {KIND_BRANCH, KIND_JUMP, KIND_JREG}) begin
      // taken: target matches the pc fetched behind it
      if (pc1_i == target2_i) begin
        code = HZ_SQUASH;
      end
    end else if ((meta_i[5].kind inside {KIND_RTYPE, KIND_ITYPE, KIND_LOAD}) &&
                 (meta_i[1].kind != KIND_JUMP) && (squash_left_q == 2'd0)) begin
      code = HZ_STRUCT;
    end
  end

  assign squash_eff = (code == HZ_SQUASH) ? SQUASH_TICKS : squash_left_q;

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      ops_o[i] = OP_SHIFT;
    end
    squash_left_d = squash_left_q;
    advance_o     = 1'b0;
    case (code)
      HZ_LOAD_NEAR, HZ_STRUCT: begin
        for (int i = 0; i < 3; i++) begin
          ops_o[i] = OP_HOLD;
        end
        ops_o[3] = OP_BUBBLE;
      end
      HZ_LOAD_FAR: begin
        for (int i = 0; i < 4; i++) begin
          ops_o[i] = OP_HOLD;
        end
        ops_o[4] = OP_BUBBLE;
      end
      default: begin
        if (squash_eff != 2'd0) begin
          ops_o[0]      = OP_HOLD;
          ops_o[1]      = OP_HOLD;
          ops_o[2]      = OP_SQUASH;
          squash_left_d = squash_eff - 2'd1;
        end else begin
          advance_o = 1'b1;
        end
      end
    endcase
    if (!tick_i) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        ops_o[i] = OP_HOLD;
      end
      squash_left_d = squash_left_q;
      advance_o     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      squash_left_q <= 2'd0;
    end else begin
      squash_left_q <= squash_left_d;
    end
  end

  assign code_o = code;

endmodule

FILE: src/pipeline_hazard_advance.sv
// top level of the seven-stage pipeline hazard and advance block
//
//   channel  dir  modport  carries
//   in_i     in   sink     one clock tick of the modeled pipe, optional instruction
//   out_o    out  source   accepted flag, stage 6 item, hazard code
//
// one item in, one item out; an item is taken every cycle while out_o.ready is high
// the row of stage cells updates on the accepting edge, and the retire item shows
// the new stage 6 contents from the next cycle on
// reset clears all slots to no-ops with zero fields and the squash counter to zero
// a result waiting in the output register blocks new items only while out_o.ready
// is low; the stage row itself never stalls the channel
module pipeline_hazard_advance import pha_pkg::*; #(
  parameter int unsigned AddrWidth = ADDR_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pha_in_if.sink    in_i,
  pha_out_if.source out_o
);

  // handshake
  logic tick;

  // entry slot built from the offered instruction
  slot_meta_t           entry_meta;
  logic [AddrWidth-1:0] entry_pc;
  logic [AddrWidth-1:0] entry_target;
  logic                 entry_ok;

  // stage row
  slot_meta_t [NUM_STAGES-1:0] meta;
  logic [AddrWidth-1:0]        pc     [NUM_STAGES];
  logic [AddrWidth-1:0]        target [NUM_STAGES];
  slot_meta_t [NUM_STAGES-1:0] prev_meta;
  logic [AddrWidth-1:0]        prev_pc     [NUM_STAGES];
  logic [AddrWidth-1:0]        prev_target [NUM_STAGES];
  cell_op_e   [NUM_STAGES-1:0] ops;

  // control results
  hazard_e code;
  logic    advance;

  // output register; the retire fields come straight from the stage 6 cell,
  // which only moves on an accepting edge
  logic    out_valid_q;
  logic    accepted_q;
  hazard_e code_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign tick       = in_i.valid && in_i.ready;

  // kinds above jump-register enter as an all-zero no-op
  assign entry_ok = in_i.instr_valid && (in_i.instr_kind <= KIND_JREG);

  always_comb begin
    entry_meta   = '0;
    entry_meta.kind = KIND_NOP;
    entry_pc     = '0;
    entry_target = '0;
    if (entry_ok) begin
      entry_meta.kind  = kind_e'(in_i.instr_kind);
      entry_meta.src_a = in_i.instr_src_a;
      entry_meta.src_b = in_i.instr_src_b;
      entry_meta.dest  = in_i.instr_dest;
      entry_pc         = AddrWidth'(in_i.instr_pc);
      entry_target     = AddrWidth'(in_i.instr_target);
    end
  end

  // hazard checks look at stages 1 to 5 and pick one move for every cell
  pha_ctrl #(
    .AddrWidth(AddrWidth)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .meta_i    (meta),
    .pc1_i     (pc[1]),
    .target2_i (target[2]),
    .ops_o     (ops),
    .code_o    (code),
    .advance_o (advance)
  );

  // cell 0 takes the entry slot, every other cell its left neighbor
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_head
      assign prev_meta[g]   = entry_meta;
      assign prev_pc[g]     = entry_pc;
      assign prev_target[g] = entry_target;
    end else begin : g_link
      assign prev_meta[g]   = meta[g-1];
      assign prev_pc[g]     = pc[g-1];
      assign prev_target[g] = target[g-1];
    end

    pha_cell #(
      .AddrWidth(AddrWidth)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (ops[g]),
      .prev_meta_i   (prev_meta[g]),
      .prev_pc_i     (prev_pc[g]),
      .prev_target_i (prev_target[g]),
      .meta_o        (meta[g]),
      .pc_o          (pc[g]),
      .target_o      (target[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // accepted only when the whole row shifted and a real offer was made
  always_ff @(posedge clk_i) begin
    if (tick) begin
      accepted_q <= advance && in_i.instr_valid;
      code_q     <= code;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accepted      = accepted_q;
  assign out_o.retire_kind   = meta[NUM_STAGES-1].kind;
  assign out_o.retire_src_a  = meta[NUM_STAGES-1].src_a;
  assign out_o.retire_src_b  = meta[NUM_STAGES-1].src_b;
  assign out_o.retire_dest   = meta[NUM_STAGES-1].dest;
  assign out_o.retire_pc     = 32'(pc[NUM_STAGES-1]);
  assign out_o.retire_target = 32'(target[NUM_STAGES-1]);
  assign out_o.hazard_code   = code_q;

endmodule
